>>> design/cc20_pkg.sv
package cc20_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned PosW        = $clog2(BlockBytes);
  localparam int unsigned DoubleRounds = 10;
  // Two rounds per double round, two half quarter-rounds per round.
  localparam int unsigned NumSteps    = 4 * DoubleRounds;
  localparam int unsigned StepW       = $clog2(NumSteps);
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  typedef logic [WordW-1:0] word_t;
  typedef logic [BlockWords-1:0][WordW-1:0] block_t;

  // "expand 32-byte k"
  localparam word_t Sigma0 = 32'h6170_7865;
  localparam word_t Sigma1 = 32'h3320_646e;
  localparam word_t Sigma2 = 32'h7962_2d32;
  localparam word_t Sigma3 = 32'h6b20_6574;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_PART_0    = 3'd0,
    CFG_KEY_PART_1    = 3'd1,
    CFG_KEY_PART_2    = 3'd2,
    CFG_KEY_PART_3    = 3'd3,
    CFG_NONCE_VALUE   = 3'd4,
    CFG_COUNTER_START = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
    word_t            counter_start;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } out_item_t;

  // Queue entry: the input item plus what the front worked out about it.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic            last_byte;
    logic            new_blk;
    logic [PosW-1:0] pos;
  } ent_t;

  typedef struct packed {
    logic start;
    logic abort;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic gen_busy;
    logic nxt_valid;
  } bk_stat_t;

  function automatic block_t build_init(cfg_t cfg, word_t counter);
    block_t b;
    b[0] = Sigma0;
    b[1] = Sigma1;
    b[2] = Sigma2;
    b[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      b[4 + 2 * i] = cfg.key[i][31:0];
      b[5 + 2 * i] = cfg.key[i][63:32];
    end
    b[12] = counter;
    b[13] = '0;
    b[14] = cfg.nonce[31:0];
    b[15] = cfg.nonce[63:32];
    return b;
  endfunction

endpackage

>>> design/cc20_fifo.sv
module cc20_fifo
  import cc20_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ent_t ent_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output ent_t head_o
);

  ent_t mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= ent_i;
    end
  end

endmodule

>>> design/cc20_core.sv
module cc20_core
  import cc20_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  input  cfg_t       cfg_i,
  input  word_t      counter_i,
  output core_stat_t stat_o,
  output block_t     block_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FEED  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  word_t            cnt_q;
  block_t           w_q, w_d;
  block_t           block_q;
  block_t           init;
  logic             diag;
  logic             half;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  // One half of a quarter round on four lanes: two add, xor, rotate steps.
  // The first half rotates by 16 and 12, the second by 8 and 7.
  function automatic block_t half_round(block_t w, logic dg, logic hf);
    block_t nw;
    int     ia, ib, ic, id;
    word_t  a1, b1, c1, d1;
    nw = w;
    for (int l = 0; l < 4; l++) begin
      ia = l;
      if (dg) begin
        ib = 4 + ((l + 1) & 3);
        ic = 8 + ((l + 2) & 3);
        id = 12 + ((l + 3) & 3);
      end else begin
        ib = 4 + l;
        ic = 8 + l;
        id = 12 + l;
      end
      a1 = w[ia] + w[ib];
      d1 = hf ? rotl(w[id] ^ a1, 8) : rotl(w[id] ^ a1, 16);
      c1 = w[ic] + d1;
      b1 = hf ? rotl(w[ib] ^ c1, 7) : rotl(w[ib] ^ c1, 12);
      nw[ia] = a1;
      nw[ib] = b1;
      nw[ic] = c1;
      nw[id] = d1;
    end
    return nw;
  endfunction

  assign half = step_q[0];
  assign diag = step_q[1];
  assign init = build_init(cfg_i, ctrl_i.start ? counter_i : cnt_q);

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_FEED);
  assign block_o     = block_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    w_d     = w_q;
    case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          state_d = ST_ROUND;
          step_d  = '0;
          w_d     = init;
        end
      end
      ST_ROUND: begin
        w_d    = half_round(w_q, diag, half);
        step_d = step_q + 1'b1;
        if (step_q == StepW'(NumSteps - 1)) begin
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (ctrl_i.abort) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (state_q == ST_IDLE && ctrl_i.start) begin
      cnt_q <= counter_i;
    end
    if (state_q == ST_FEED) begin
      for (int i = 0; i < BlockWords; i++) begin
        block_q[i] <= w_q[i] + init[i];
      end
    end
  end

endmodule

>>> design/cc20_front.sv
module cc20_front
  import cc20_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     push_o,
  output ent_t     ent_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            msg_start_q, msg_start_d;
  logic [PosW-1:0] pos;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // A byte that begins a message always sits at the head of a block.
  assign pos = msg_start_q ? '0 : pos_q;

  assign ent_o.data_byte = in_data_i.data_byte;
  assign ent_o.last_byte = in_data_i.last_byte;
  assign ent_o.new_blk   = msg_start_q || (pos_q == '0);
  assign ent_o.pos       = pos;

  always_comb begin
    pos_d       = pos_q;
    msg_start_d = msg_start_q;
    if (push_o) begin
      pos_d       = pos + 1'b1;
      msg_start_d = in_data_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      msg_start_q <= 1'b1;
    end else begin
      pos_q       <= pos_d;
      msg_start_q <= msg_start_d;
    end
  end

endmodule

>>> design/cc20_back.sv
module cc20_back
  import cc20_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cfg_we_i,
  input  logic      head_valid_i,
  input  ent_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i,
  output bk_stat_t  stat_o
);

  block_t     cur_q;
  word_t      cur_cnt_q;
  word_t      tgt_q;
  logic       nxt_valid_q;
  logic       msg_end_q;
  logic       out_valid_q;
  out_item_t  out_q;

  core_ctrl_t core_ctrl;
  core_stat_t core_stat;
  block_t     core_blk;
  word_t      tgt_start;
  logic       msg_end_eff;
  logic       out_free;
  logic       blk_ok;
  logic       swap;
  logic       abort_gen;
  block_t     ks_blk;
  word_t      ks_word;
  logic [7:0] ks_byte;

  cc20_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (core_ctrl),
    .cfg_i     (cfg_i),
    .counter_i (tgt_start),
    .stat_o    (core_stat),
    .block_o   (core_blk)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign blk_ok   = !head_i.new_blk || nxt_valid_q;
  assign pop_o    = head_valid_i && out_free && blk_ok;
  assign swap     = pop_o && head_i.new_blk;

  // The prefetched block is guessed to continue the message. Once the last
  // byte goes by, the next block must be the message start block instead.
  assign msg_end_eff = pop_o ? head_i.last_byte : msg_end_q;
  assign tgt_start   = msg_end_eff ? cfg_i.counter_start : cur_cnt_q + 32'd1;
  assign abort_gen   = pop_o && head_i.last_byte && !head_i.new_blk &&
                       (nxt_valid_q || core_stat.busy) &&
                       (tgt_q != cfg_i.counter_start);

  assign core_ctrl.start = !nxt_valid_q && !core_stat.busy && !cfg_we_i;
  assign core_ctrl.abort = abort_gen || cfg_we_i;

  assign ks_blk  = head_i.new_blk ? core_blk : cur_q;
  assign ks_word = ks_blk[head_i.pos[PosW-1:2]];
  assign ks_byte = ks_word[{head_i.pos[1:0], 3'b000} +: 8];

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.gen_busy  = core_stat.busy;
  assign stat_o.nxt_valid = nxt_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_valid_q <= 1'b0;
      msg_end_q   <= 1'b1;
      out_valid_q <= 1'b0;
      cur_cnt_q   <= '0;
      tgt_q       <= '0;
    end else begin
      if (core_ctrl.abort || swap) begin
        nxt_valid_q <= 1'b0;
      end else if (core_stat.done) begin
        nxt_valid_q <= 1'b1;
      end
      if (core_ctrl.start) begin
        tgt_q <= tgt_start;
      end
      if (swap) begin
        cur_cnt_q <= tgt_q;
      end
      if (pop_o) begin
        msg_end_q   <= head_i.last_byte;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (swap) begin
      cur_q <= core_blk;
    end
    if (pop_o) begin
      out_q.result_byte <= head_i.data_byte ^ ks_byte;
      out_q.result_last <= head_i.last_byte;
    end
  end

endmodule

>>> design/chacha20_stream_cipher_unit.sv
// ChaCha20 byte-stream cipher with a 256-bit key, 64-bit nonce and 32-bit
// block counter. Each transfer on the input carries one byte and yields one
// output transfer with that byte XORed with the keystream, in order. Inside a
// message the unit takes one byte per cycle unless stalled: the block
// generator runs one half quarter-round on four lanes each cycle, so a
// 64-byte block takes a load, 40 round steps and a feed-forward, and the next
// block is computed while the current one is used. The first byte of a
// message waits for its block, which is started when the previous message's
// last byte leaves the queue, so a new message waits for that block unless
// it is already prefetched. A four-entry queue sits between the input side
// and the keystream side, and the result is held in an output register.
// Configuration writes are always ready and restart any block in progress.
module chacha20_stream_cipher_unit
  import cc20_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t     cfg_q, cfg_d;
  logic     cfg_we;
  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  ent_t     q_in;
  ent_t     q_head;
  bk_stat_t bk_stat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d  = cfg_q;
    cfg_we = 1'b0;
    if (cfg_valid_i) begin
      cfg_we = 1'b1;
      case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_PART_0:    cfg_d.key[0] = cfg_data_i;
        CFG_KEY_PART_1:    cfg_d.key[1] = cfg_data_i;
        CFG_KEY_PART_2:    cfg_d.key[2] = cfg_data_i;
        CFG_KEY_PART_3:    cfg_d.key[3] = cfg_data_i;
        CFG_NONCE_VALUE:   cfg_d.nonce  = cfg_data_i;
        CFG_COUNTER_START: cfg_d.counter_start = cfg_data_i[WordW-1:0];
        default:           cfg_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cc20_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .ent_o      (q_in)
  );

  cc20_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ent_i   (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  cc20_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cfg_we_i     (cfg_we),
    .head_valid_i (!q_empty),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i),
    .stat_o       (bk_stat)
  );

  // The queue is never read while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A new result appears only after an entry was taken from the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(q_pop))
    else $error("result produced without a queue entry");

  // The generator never runs while a prefetched block is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bk_stat.gen_busy && bk_stat.nxt_valid))
    else $error("block generator running over a pending block");

endmodule
